// ===== rtl/core/wfpa_pkg.sv =====
// Shared types, codes and reset tables for the worst-fit partition allocator.
package wfpa_pkg;

  localparam int PARTITIONS   = 8;
  localparam int ADDRESS_BITS = 10;
  localparam int IDX_W        = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int SIZE_W       = 10;
  localparam int DEFAULT_COUNT = 6;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] req_size;
    logic [9:0] address;
    logic [2:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] alloc_address;
    logic [2:0] chosen_entry;
  } rsp_t;

  // The travelling token: the command plus the running scan result.
  typedef struct packed {
    logic                    valid;
    logic [1:0]              cmd;
    logic [SIZE_W-1:0]       size;
    logic [ADDRESS_BITS-1:0] addr;
    logic [2:0]              entry_index;
    logic                    found;
    logic [SIZE_W-1:0]       best;
    logic [IDX_W-1:0]        pick;
    logic [ADDRESS_BITS-1:0] pick_base;
    logic                    hit;
  } token_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } grant_t;

  function automatic logic [ADDRESS_BITS-1:0] default_base(input int i);
    logic [ADDRESS_BITS-1:0] v;
    case (i)
      0:       v = ADDRESS_BITS'(0);
      1:       v = ADDRESS_BITS'(100);
      2:       v = ADDRESS_BITS'(150);
      3:       v = ADDRESS_BITS'(160);
      4:       v = ADDRESS_BITS'(180);
      5:       v = ADDRESS_BITS'(280);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [SIZE_W-1:0] default_size(input int i);
    logic [SIZE_W-1:0] v;
    case (i)
      0:       v = SIZE_W'(100);
      1:       v = SIZE_W'(50);
      2:       v = SIZE_W'(10);
      3:       v = SIZE_W'(20);
      4:       v = SIZE_W'(200);
      5:       v = SIZE_W'(110);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/wfpa_cell.sv =====
// One partition table entry that updates and forwards the scan token.
module wfpa_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [wfpa_pkg::IDX_W-1:0] cell_index,
  input  wfpa_pkg::token_t       tok_in,
  input  wfpa_pkg::grant_t       grant,
  output wfpa_pkg::token_t       tok_out
);
  import wfpa_pkg::*;

  logic [ADDRESS_BITS-1:0] part_base;
  logic [SIZE_W-1:0]       part_size;
  logic                    part_busy;
  token_t                  tok_next;
  logic                    base_match;
  logic                    load_match;
  logic                    granted;

  assign base_match = (part_base == tok_in.addr);
  assign load_match = (32'(tok_in.entry_index) == 32'(cell_index));
  assign granted    = grant.valid && (grant.index == cell_index);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid) begin
      case (tok_in.cmd)
        CMD_ALLOC: begin
          // Equal sizes favor the later entry, hence the <= compare.
          if (!part_busy && (tok_in.best <= part_size)) begin
            tok_next.found     = 1'b1;
            tok_next.best      = part_size;
            tok_next.pick      = cell_index;
            tok_next.pick_base = part_base;
          end
        end
        CMD_FREE: begin
          if (base_match) begin
            tok_next.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_base     <= default_base(int'(cell_index));
      part_size     <= default_size(int'(cell_index));
      part_busy     <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.valid && (tok_in.cmd == CMD_FREE) && base_match) begin
        part_busy <= 1'b0;
      end
      if (tok_in.valid && (tok_in.cmd == CMD_LOAD) && load_match) begin
        part_base <= tok_in.addr;
        part_size <= tok_in.size;
        part_busy <= 1'b0;
      end
      if (granted) begin
        part_busy <= 1'b1;
      end
    end
  end

  // Only one beat is in flight, so a grant never meets a passing token.
  a_grant_alone: assert property (@(posedge clk) disable iff (rst)
    !(grant.valid && tok_in.valid))
    else $error("grant arrived while a token passes the cell");

  // A grant always lands on an entry the scan saw as free.
  a_grant_free: assert property (@(posedge clk) disable iff (rst)
    granted |-> !part_busy)
    else $error("grant on a busy partition");

  a_grant_sets_busy: assert property (@(posedge clk) disable iff (rst)
    granted |=> part_busy)
    else $error("granted partition not marked busy");

endmodule

// ===== rtl/core/worst_fit_partition_allocator_unit.sv =====
// Top level of the worst-fit partition allocator: launch, cell row and result stage.
//
//  channel   ports                    direction  accepted when
//  request   start, busy, request     in         start && !busy at a rising edge
//  result    done, result             out        every cycle done is high
//
// Every command, whatever its kind, travels as one token along the row of
// PARTITIONS cells, one cell per cycle, from the launch register through the
// cell registers to the registered done strobe; the length of the cell row
// sets how long a beat takes. busy is high from the accepting edge until the
// edge that raises done, so a new start may be taken while done is shown.
// Reset loads the six built-in partitions and clears every busy mark at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module worst_fit_partition_allocator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  wfpa_pkg::req_t   request,
  output logic             done,
  output wfpa_pkg::rsp_t   result
);
  import wfpa_pkg::*;

  // tok[0] is the launch register; tok[i+1] is the register of cell i.
  token_t tok [0:PARTITIONS];
  grant_t grant;
  rsp_t   result_next;
  token_t tail;
  logic   accept;

  assign accept = start && !busy;
  assign tail   = tok[PARTITIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid       <= accept;
      tok[0].cmd         <= request.cmd;
      tok[0].size        <= SIZE_W'(request.req_size);
      tok[0].addr        <= ADDRESS_BITS'(request.address);
      tok[0].entry_index <= request.entry_index;
      tok[0].found       <= 1'b0;
      tok[0].best        <= '0;
      tok[0].pick        <= '0;
      tok[0].pick_base   <= '0;
      tok[0].hit         <= 1'b0;
    end
  end

  for (genvar g = 0; g < PARTITIONS; g++) begin : g_cell
    wfpa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(g)),
      .tok_in     (tok[g]),
      .grant      (grant),
      .tok_out    (tok[g+1])
    );
  end

  // When the token leaves the last cell the scan result is final. A granted
  // allocate sends the winning index back to its cell in the same cycle.
  always_comb begin
    result_next = '0;
    result_next.status = ST_DONE;
    grant = '0;
    if (tail.valid) begin
      case (tail.cmd)
        CMD_ALLOC: begin
          if (tail.found && (tail.best >= tail.size)) begin
            result_next.alloc_address = 10'(tail.pick_base);
            result_next.chosen_entry  = 3'(tail.pick);
            grant.valid = 1'b1;
            grant.index = tail.pick;
          end else begin
            result_next.status = ST_NO_SPACE;
          end
        end
        CMD_FREE: begin
          result_next.status = tail.hit ? ST_DONE : ST_NO_MATCH;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done   <= tail.valid;
      result <= result_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done strobe while a beat is still in flight");

  a_done_from_tail: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(tail.valid))
    else $error("done without a token leaving the cell row");

  a_no_grant_on_failure: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_DONE)) |-> (result.alloc_address == '0))
    else $error("address reported on a failed request");

endmodule
